// File: rtl/core/utra_pkg.sv
// Shared types, constants and helpers for the unsigned-to-radix ASCII converter.
`default_nettype none

package utra_pkg;

  localparam int InWidth      = 64;
  localparam int RadixWidth   = 5;
  localparam int CharWidth    = 8;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 5;

  localparam logic [RadixWidth-1:0] RadixReset = 5'd10;
  localparam logic [RadixWidth-1:0] RadixMin   = 5'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 5'd16;

  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
  localparam logic [CharWidth-1:0] CharUpperA = 8'h41;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRadix = 2'd0,
    CfgUpper = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [RadixWidth-1:0] radix;
    logic                  upper;
  } cfg_t;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 last;
  } out_item_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] digit,
                                                      input logic       upper);
    logic [CharWidth-1:0] base;
    if (digit < 4'd10) begin
      base = CharZero;
    end else if (upper) begin
      base = CharUpperA - 8'd10;
    end else begin
      base = CharLowerA - 8'd10;
    end
    return base + {4'b0000, digit};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/utra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module utra_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/utra_fifo.sv
// Small register-based FIFO with occupancy count.
`default_nettype none

module utra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  output logic                            full_o,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           data_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/utra_front.sv
// Front end: masks and classifies input beats, queues them for the back end.
`default_nettype none

module utra_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [utra_pkg::InWidth-1:0] value_i,
  output logic                            full_o,
  input  wire logic                       work_pop_i,
  output logic                            work_valid_o,
  output logic      [VALUE_WIDTH:0]       work_o
);

  logic [VALUE_WIDTH-1:0] masked;
  logic                   is_zero;
  logic                   work_empty;
  logic [1:0]             work_cnt;

  assign masked  = value_i[VALUE_WIDTH-1:0];
  assign is_zero = ~|masked;

  // queue item: {is_zero, masked value}
  utra_fifo #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (2)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  ({is_zero, masked}),
    .full_o  (full_o),
    .pop_i   (work_pop_i),
    .data_o  (work_o),
    .empty_o (work_empty),
    .count_o (work_cnt)
  );

  assign work_valid_o = !work_empty && (work_cnt != 2'd0);

endmodule

`default_nettype wire

// File: rtl/core/utra_back.sv
// Back end: bit-serial radix divider, digit RAM and most-significant-first readout.
`default_nettype none

module utra_back #(
  parameter int VALUE_WIDTH = 64,
  parameter int OUT_DEPTH   = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire utra_pkg::cfg_t                 cfg_i,
  input  wire logic                           work_valid_i,
  input  wire logic [VALUE_WIDTH:0]           work_i,
  output logic                                work_pop_o,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                out_push_o,
  output utra_pkg::out_item_t                 out_item_o
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int BW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {
    BkIdle = 3'b001,
    BkDiv  = 3'b010,
    BkEmit = 3'b100
  } back_state_e;

  back_state_e                       state_q, state_d;
  logic [VALUE_WIDTH-1:0]            quo_q, quo_d;
  logic [3:0]                        rem_q, rem_d;
  logic [BW-1:0]                     bit_q, bit_d;
  logic [utra_pkg::RadixWidth-1:0]   rad_q, rad_d;
  logic [AW-1:0]                     wa_q, wa_d;
  logic [AW-1:0]                     ra_q, ra_d;
  logic                              infl_q, infl_d;
  logic                              infl_last_q, infl_last_d;

  logic [4:0]             trial;
  logic                   ge;
  logic [3:0]             rem_n;
  logic [VALUE_WIDTH-1:0] quo_n;
  logic                   room;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr;
  logic [3:0]             ram_wdata, ram_rdata;

  // one quotient bit per cycle
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign ge    = (trial >= rad_q);
  assign rem_n = ge ? 4'(trial - rad_q) : trial[3:0];
  assign quo_n = {quo_q[VALUE_WIDTH-2:0], ge};

  // credit: reads in flight plus queued beats never exceed the output queue
  assign room = ((out_count_i + CW'(infl_q)) < CW'(OUT_DEPTH));

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    rad_d       = rad_q;
    wa_d        = wa_q;
    ra_d        = ra_q;
    infl_d      = 1'b0;
    infl_last_d = infl_last_q;
    work_pop_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = rem_n;
    ram_re      = 1'b0;
    case (state_q)
      BkIdle: begin
        if (work_valid_i) begin
          work_pop_o = 1'b1;
          rad_d      = cfg_i.radix;
          if (work_i[VALUE_WIDTH]) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = 4'd0;
            ra_d      = '0;
            state_d   = BkEmit;
          end else begin
            quo_d   = work_i[VALUE_WIDTH-1:0];
            rem_d   = 4'd0;
            bit_d   = BW'(VALUE_WIDTH - 1);
            wa_d    = '0;
            state_d = BkDiv;
          end
        end
      end
      BkDiv: begin
        quo_d = quo_n;
        rem_d = rem_n;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          ram_we = 1'b1;
          if (quo_n == '0) begin
            ra_d    = wa_q;
            state_d = BkEmit;
          end else begin
            wa_d  = wa_q + 1'b1;
            rem_d = 4'd0;
            bit_d = BW'(VALUE_WIDTH - 1);
          end
        end
      end
      BkEmit: begin
        if (room) begin
          ram_re      = 1'b1;
          infl_d      = 1'b1;
          infl_last_d = (ra_q == '0);
          ra_d        = ra_q - 1'b1;
          if (ra_q == '0) begin
            state_d = BkIdle;
          end
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      infl_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      infl_q  <= infl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    bit_q       <= bit_d;
    rad_q       <= rad_d;
    wa_q        <= wa_d;
    ra_q        <= ra_d;
    infl_last_q <= infl_last_d;
  end

  utra_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ra_q),
    .rdata_o (ram_rdata)
  );

  assign out_push_o           = infl_q;
  assign out_item_o.character = utra_pkg::digit_char(ram_rdata, cfg_i.upper);
  assign out_item_o.last      = infl_last_q;

endmodule

`default_nettype wire

// File: rtl/core/unsigned_to_radix_ascii.sv
// Top level: unsigned value to ASCII digits in a configurable radix.
//
//   channel   direction  handshake             payload
//   input     in         push / full           value_i
//   result    out        empty / pop           character_o, last_o
//   config    in         cfg_we_i, cfg_idx_i   cfg_data_i
//
// A nonzero value is divided by the radix in the bit-serial divider, one
// division per digit, then its digits are read out of the digit RAM;
// zero skips the divider and writes a single zero digit.
// Reset clears control state only; the digit RAM needs no clearing pass.
// The input queue takes items while the back end works; a stalled pop
// holds the readout through the output queue credit.
`default_nettype none

module unsigned_to_radix_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [utra_pkg::InWidth-1:0]       value_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic      [utra_pkg::CharWidth-1:0]     character_o,
  output logic                                    last_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [utra_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [utra_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int OutDepth = 4;
  localparam int OCW      = $clog2(OutDepth + 1);

  logic [utra_pkg::RadixWidth-1:0] radix_q, radix_d;
  logic                            upper_q, upper_d;
  utra_pkg::cfg_t                  cfg;
  logic                            work_valid, work_pop;
  logic [VALUE_WIDTH:0]            work;
  logic [OCW-1:0]                  out_count;
  logic                            out_push;
  utra_pkg::out_item_t             out_item, out_head;

  always_comb begin
    radix_d = radix_q;
    upper_d = upper_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        utra_pkg::CfgRadix: begin
          if (cfg_data_i < utra_pkg::RadixMin) begin
            radix_d = utra_pkg::RadixMin;
          end else if (cfg_data_i > utra_pkg::RadixMax) begin
            radix_d = utra_pkg::RadixMax;
          end else begin
            radix_d = cfg_data_i;
          end
        end
        utra_pkg::CfgUpper: begin
          upper_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= utra_pkg::RadixReset;
      upper_q <= 1'b0;
    end else begin
      radix_q <= radix_d;
      upper_q <= upper_d;
    end
  end

  assign cfg.radix = radix_q;
  assign cfg.upper = upper_q;

  utra_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .value_i      (value_i),
    .full_o       (full),
    .work_pop_i   (work_pop),
    .work_valid_o (work_valid),
    .work_o       (work)
  );

  utra_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .OUT_DEPTH   (OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .work_valid_i (work_valid),
    .work_i       (work),
    .work_pop_o   (work_pop),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_item_o   (out_item)
  );

  utra_fifo #(
    .WIDTH ($bits(utra_pkg::out_item_t)),
    .DEPTH (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_head),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign character_o = out_head.character;
  assign last_o      = out_head.last;

endmodule

`default_nettype wire

// File: rtl/core/utra_checker.sv
// Port-level checker for the radix converter, bound to the top level.
`default_nettype none

module utra_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] character_i,
  input wire logic       last_i
);

  // both queues come out of reset drained
  a_reset_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not drained after reset");

  // every beat is an ASCII digit or letter a-f / A-F
  a_digit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((character_i >= 8'h30 && character_i <= 8'h39) ||
                (character_i >= 8'h41 && character_i <= 8'h46) ||
                (character_i >= 8'h61 && character_i <= 8'h66)))
    else $error("result is not a radix digit");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(character_i) && $stable(last_i)))
    else $error("result beat changed while stalled");

endmodule

bind unsigned_to_radix_ascii utra_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .character_i (character_o),
  .last_i      (last_o)
);

`default_nettype wire

// File: sim/unsigned_to_radix_ascii_tb.sv
// Self-checking testbench for the unsigned-to-radix ASCII converter.
`default_nettype none

module unsigned_to_radix_ascii_tb;

  localparam int InW = utra_pkg::InWidth;
  localparam int CdW = utra_pkg::CfgDataWidth;
  localparam logic [utra_pkg::CfgIdxWidth-1:0] CfgSpare2 = 2'd2;
  localparam logic [utra_pkg::CfgIdxWidth-1:0] CfgSpare3 = 2'd3;
  localparam int SettlePad = 50;
  localparam string LowerDigits = "0123456789abcdef";
  localparam string UpperDigits = "0123456789ABCDEF";

  typedef enum logic {RowWrite, RowValue} row_kind_e;

  typedef struct {
    row_kind_e                           kind;
    logic [utra_pkg::CfgIdxWidth-1:0]    idx;
    logic [utra_pkg::CfgDataWidth-1:0]   data;
    logic [utra_pkg::InWidth-1:0]        value;
    string                               text;
  } stim_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              push;
  logic                              full;
  logic [utra_pkg::InWidth-1:0]      value_i;
  logic                              empty;
  logic                              pop;
  logic [utra_pkg::CharWidth-1:0]    character_o;
  logic                              last_o;
  logic                              cfg_we_i;
  logic [utra_pkg::CfgIdxWidth-1:0]  cfg_idx_i;
  logic [utra_pkg::CfgDataWidth-1:0] cfg_data_i;

  utra_pkg::out_item_t char_q[$];
  int                  n_fail;
  int                  cur_radix;
  logic                cur_upper;
  bit                  steady;

  // Table of directed register writes and beats; empty text on a beat means the digits come from the predictor.
  stim_row_t dir_rows [34] = '{
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd0, "0"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd1, "1"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd9, "9"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd10, "10"},
    '{RowWrite, utra_pkg::CfgRadix, 5'd16, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hAB_CDEF, "abcdef"},
    '{RowWrite, utra_pkg::CfgUpper, 5'd1, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hAB_CDEF, "ABCDEF"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'h8000_0000_0000_0000, "8000000000000000"},
    '{RowWrite, utra_pkg::CfgUpper, 5'b11110, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hFA, "fa"},
    '{RowWrite, CfgSpare2, 5'd3, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd255, "ff"},
    '{RowWrite, CfgSpare3, 5'd5, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd16, "10"},
    '{RowWrite, utra_pkg::CfgRadix, 5'd0, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd5, "101"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'h8000_0000_0000_0000, ""},
    '{RowWrite, utra_pkg::CfgRadix, 5'd1, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd2, "10"},
    '{RowWrite, utra_pkg::CfgRadix, 5'd17, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd255, "ff"},
    '{RowWrite, utra_pkg::CfgRadix, 5'd31, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd4095, "fff"},
    '{RowWrite, utra_pkg::CfgRadix, 5'd3, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd8, "22"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{RowWrite, utra_pkg::CfgRadix, 5'd15, 64'd0, ""},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd14, "e"},
    '{RowValue, utra_pkg::CfgRadix, 5'd0, 64'd0, "0"},
    '{RowWrite, utra_pkg::CfgRadix, 5'd20, 64'd0, ""}
  };

  unsigned_to_radix_ascii u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .character_o(character_o),
    .last_o     (last_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // Repeated division by the radix, digits emitted most significant first.
  function automatic void predict_digits(input logic [utra_pkg::InWidth-1:0] v);
    logic [utra_pkg::InWidth-1:0] quo;
    logic [3:0]                   digs[$];
    utra_pkg::out_item_t          item;
    quo = v;
    if (quo == '0) digs.push_back(4'd0);
    while (quo != '0) begin
      digs.push_front(4'(quo % InW'(cur_radix)));
      quo = quo / InW'(cur_radix);
    end
    foreach (digs[i]) begin
      item.character = cur_upper ? UpperDigits[digs[i]] : LowerDigits[digs[i]];
      item.last      = (i == digs.size() - 1);
      char_q.push_back(item);
    end
  endfunction

  function automatic void expect_text(input string text);
    utra_pkg::out_item_t item;
    for (int i = 0; i < text.len(); i++) begin
      item.character = text[i];
      item.last      = (i == text.len() - 1);
      char_q.push_back(item);
    end
  endfunction

  function automatic logic [utra_pkg::InWidth-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 13) return '1;
    return {$urandom(), $urandom()} >> $urandom_range(0, utra_pkg::InWidth - 1);
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (SettlePad) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [utra_pkg::CfgIdxWidth-1:0] idx,
                           input logic [utra_pkg::CfgDataWidth-1:0] data);
    int r;
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == utra_pkg::CfgRadix) begin
      r = int'(data);
      cur_radix = (r < int'(utra_pkg::RadixMin)) ? int'(utra_pkg::RadixMin) :
                  (r > int'(utra_pkg::RadixMax)) ? int'(utra_pkg::RadixMax) : r;
    end else if (idx == utra_pkg::CfgUpper) begin
      cur_upper = data[0];
    end
    @(posedge clk_i);
  endtask

  // Expected digits are queued at the edge where the beat is taken.
  task automatic send_value(input logic [utra_pkg::InWidth-1:0] v, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (full);
    if (text.len() != 0) expect_text(text);
    else predict_digits(v);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    value_i    <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= utra_pkg::CfgRadix;
    cfg_data_i <= '0;
    n_fail     = 0;
    cur_radix  = int'(utra_pkg::RadixReset);
    cur_upper  = 1'b0;
    steady     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowWrite) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_value(dir_rows[i].value, dir_rows[i].text);
    end
    write_reg(utra_pkg::CfgUpper, 5'd0);

    for (int p = 0; p < 8; p++) begin
      if (p == 0) write_reg(utra_pkg::CfgRadix, utra_pkg::RadixMin);
      else if (p == 1) write_reg(utra_pkg::CfgRadix, utra_pkg::RadixMax);
      else write_reg(utra_pkg::CfgRadix, CdW'($urandom_range(0, 31)));
      write_reg(utra_pkg::CfgUpper, CdW'($urandom_range(0, 31)));
      if (p == 4) write_reg(CfgSpare3, CdW'($urandom_range(0, 31)));
      steady = (p % 3 == 2);
      repeat (25) send_value(rand_value(), "");
    end

    drain();
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int burst;
    int gap;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      burst = steady ? $urandom_range(20, 80) : $urandom_range(1, 8);
      pop <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    utra_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (char_q.size() == 0) begin
        $error("unexpected beat: character %h last %b", character_o, last_o);
        n_fail++;
      end else begin
        want = char_q.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected %h, got %h", want.character, character_o);
          n_fail++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          n_fail++;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/utra_pkg.sv
rtl/core/utra_ram.sv
rtl/core/utra_fifo.sv
rtl/core/utra_front.sv
rtl/core/utra_back.sv
rtl/core/unsigned_to_radix_ascii.sv
rtl/core/utra_checker.sv
sim/unsigned_to_radix_ascii_tb.sv
